// ===== src/bcc_pkg.sv =====
package bcc_pkg;

  // Width of the key level snapshot carried by each input beat.
  localparam int unsigned LEVEL_BITS = 16;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned KEY_IDX_W  = 4;

  // Configuration register indexes.
  localparam logic [0:0] CFG_DEBOUNCE = 1'b0;
  localparam logic [0:0] CFG_LIMIT    = 1'b1;

  // Register values after reset.
  localparam logic [TICK_W-1:0] DEBOUNCE_RST = 32'd30;
  localparam logic [TICK_W-1:0] LIMIT_RST    = 32'd300;

  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_RELEASE = 3'd1,
    EV_LONG    = 3'd2,
    EV_DOUBLE  = 3'd3,
    EV_SHORT   = 3'd4
  } ev_kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_item;  // capture the input beat
    logic       calc;       // read key state, register the elapsed time
    logic       decide;     // update key state, latch the key's events
    logic       take;       // move one latched event into the hold slot
    logic       slot;       // which latched event to take
    logic       push;       // move the hold slot into the output register
    logic       push_last;  // the pushed beat ends the item
  } bcc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       hold_valid;
    logic       out_free;
    logic [1:0] ev_cnt;
  } bcc_status_t;

endpackage

// ===== src/bcc_if.sv =====
interface bcc_in_if import bcc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] key_levels;
  logic [TICK_W-1:0]     now_ticks;

  modport source (output valid, key_levels, now_ticks, input ready);
  modport sink   (input valid, key_levels, now_ticks, output ready);
endinterface

interface bcc_out_if import bcc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [KEY_IDX_W-1:0] key_index;
  logic [2:0]           event_kind;
  logic [TICK_W-1:0]    held_ticks;
  logic                 last;

  modport source (output valid, key_index, event_kind, held_ticks, last, input ready);
  modport sink   (input valid, key_index, event_kind, held_ticks, last, output ready);
endinterface

// ===== src/bcc_ctrl.sv =====
module bcc_ctrl import bcc_pkg::*; #(
  parameter int unsigned NUM_KEYS = 16,
  parameter int unsigned KW       = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bcc_status_t   st_i,
  output bcc_cmd_t      cmd_o,
  output logic [KW-1:0] key_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_DECIDE,
    S_EMIT,
    S_FLUSH
  } state_e;

  localparam logic [KW-1:0] LAST_KEY = KW'(NUM_KEYS - 1);

  state_e        state_q, state_d;
  logic [KW-1:0] key_q, key_d;
  logic [1:0]    slot_q, slot_d;

  always_comb begin
    state_d    = state_q;
    key_d      = key_q;
    slot_d     = slot_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          key_d           = '0;
          state_d         = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        slot_d       = '0;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (slot_q != st_i.ev_cnt) begin
          // The held event can only leave once the output register has room.
          if (!st_i.hold_valid || st_i.out_free) begin
            cmd_o.take = 1'b1;
            cmd_o.slot = slot_q[0];
            cmd_o.push = st_i.hold_valid;
            slot_d     = slot_q + 2'd1;
          end
        end else if (key_q == LAST_KEY) begin
          state_d = S_FLUSH;
        end else begin
          key_d   = key_q + KW'(1);
          state_d = S_CALC;
        end
      end
      S_FLUSH: begin
        if (!st_i.hold_valid) begin
          state_d = S_IDLE;
        end else if (st_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_last = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      key_q   <= '0;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      key_q   <= key_d;
      slot_q  <= slot_d;
    end
  end

  assign key_o = key_q;

endmodule

// ===== src/bcc_datapath.sv =====
module bcc_datapath import bcc_pkg::*; #(
  parameter int unsigned NUM_KEYS = 16,
  parameter int unsigned KW       = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_idx_i,
  input  logic [TICK_W-1:0]     cfg_data_i,
  input  logic [LEVEL_BITS-1:0] key_levels_i,
  input  logic [TICK_W-1:0]     now_ticks_i,
  input  bcc_cmd_t              cmd_i,
  input  logic [KW-1:0]         key_i,
  output bcc_status_t           st_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [KEY_IDX_W-1:0]  key_index_o,
  output logic [2:0]            event_kind_o,
  output logic [TICK_W-1:0]     held_ticks_o,
  output logic                  last_o
);

  typedef enum logic [1:0] {
    PH_RELEASED    = 2'd0,
    PH_FIRST_DOWN  = 2'd1,
    PH_WAITING     = 2'd2,
    PH_SECOND_DOWN = 2'd3
  } phase_e;

  logic [TICK_W-1:0]     db_q, lim_q;
  logic [LEVEL_BITS-1:0] levels_q;
  logic [TICK_W-1:0]     now_q;
  phase_e                phase_q [NUM_KEYS];
  logic [TICK_W-1:0]     time_q  [NUM_KEYS];
  logic [NUM_KEYS-1:0]   lvl_all;

  logic [TICK_W-1:0]     elapsed_q;
  phase_e                cur_phase_q;
  logic                  pressed_q;

  ev_kind_e              ev_kind_q [2];
  ev_kind_e              ev_kind_d [2];
  logic [1:0]            ev_cnt_q, ev_cnt_d;
  phase_e                next_phase;
  logic                  write_time;
  logic                  gt_db, lt_lim;

  logic                  hold_valid_q;
  logic [KEY_IDX_W-1:0]  hold_key_q;
  ev_kind_e              hold_kind_q;
  logic [TICK_W-1:0]     hold_held_q;
  logic                  out_valid_q;
  logic [KEY_IDX_W-1:0]  out_key_q;
  ev_kind_e              out_kind_q;
  logic [TICK_W-1:0]     out_held_q;
  logic                  out_last_q;

  logic [31:0]           key_wide;
  logic [KEY_IDX_W-1:0]  key4;
  ev_kind_e              take_kind;

  // Keys beyond the level bits never read as pressed.
  always_comb begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (i < LEVEL_BITS) begin
        lvl_all[i] = levels_q[i % LEVEL_BITS];
      end else begin
        lvl_all[i] = 1'b0;
      end
    end
  end

  assign gt_db = elapsed_q > db_q;
  assign lt_lim = elapsed_q < lim_q;

  always_comb begin
    next_phase   = cur_phase_q;
    write_time   = 1'b0;
    ev_cnt_d     = 2'd0;
    ev_kind_d[0] = EV_PRESS;
    ev_kind_d[1] = EV_LONG;
    case (cur_phase_q)
      PH_RELEASED: begin
        if (pressed_q) begin
          next_phase   = PH_FIRST_DOWN;
          write_time   = 1'b1;
          ev_cnt_d     = 2'd1;
          ev_kind_d[0] = EV_PRESS;
        end
      end
      PH_FIRST_DOWN: begin
        if (gt_db && !pressed_q) begin
          ev_kind_d[0] = EV_RELEASE;
          if (lt_lim) begin
            next_phase = PH_WAITING;
            write_time = 1'b1;
            ev_cnt_d   = 2'd1;
          end else begin
            next_phase   = PH_RELEASED;
            ev_cnt_d     = 2'd2;
            ev_kind_d[1] = EV_LONG;
          end
        end
      end
      PH_WAITING: begin
        // The double click and the window timeout exclude each other.
        if (gt_db && pressed_q && lt_lim) begin
          next_phase   = PH_SECOND_DOWN;
          write_time   = 1'b1;
          ev_cnt_d     = 2'd1;
          ev_kind_d[0] = EV_DOUBLE;
        end else if (!lt_lim) begin
          next_phase   = PH_RELEASED;
          ev_cnt_d     = 2'd1;
          ev_kind_d[0] = EV_SHORT;
        end
      end
      PH_SECOND_DOWN: begin
        if (gt_db && !pressed_q) begin
          next_phase = PH_RELEASED;
        end
      end
      default: begin
        next_phase = PH_RELEASED;
      end
    endcase
  end

  assign key_wide  = 32'(key_i);
  assign key4      = key_wide[KEY_IDX_W-1:0];
  assign take_kind = ev_kind_q[cmd_i.slot];

  // Configuration registers and key phases.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      db_q  <= DEBOUNCE_RST;
      lim_q <= LIMIT_RST;
      for (int i = 0; i < NUM_KEYS; i++) begin
        phase_q[i] <= PH_RELEASED;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEBOUNCE: db_q  <= cfg_data_i;
          CFG_LIMIT:    lim_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.decide) begin
        phase_q[key_i] <= next_phase;
      end
    end
  end

  // Item, per-key working values, event timestamps and the hold and output data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      levels_q <= key_levels_i;
      now_q    <= now_ticks_i;
    end
    if (cmd_i.calc) begin
      elapsed_q   <= now_q - time_q[key_i];
      cur_phase_q <= phase_q[key_i];
      pressed_q   <= lvl_all[key_i];
    end
    if (cmd_i.decide) begin
      ev_kind_q[0] <= ev_kind_d[0];
      ev_kind_q[1] <= ev_kind_d[1];
      if (write_time) begin
        time_q[key_i] <= now_q;
      end
    end
    if (cmd_i.take) begin
      hold_key_q  <= key4;
      hold_kind_q <= take_kind;
      hold_held_q <= (take_kind == EV_LONG) ? elapsed_q : '0;
    end
    if (cmd_i.push) begin
      out_key_q  <= hold_key_q;
      out_kind_q <= hold_kind_q;
      out_held_q <= hold_held_q;
      out_last_q <= cmd_i.push_last;
    end
  end

  // Valid flags of the hold slot and the output register, and the event count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_cnt_q     <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.decide) begin
        ev_cnt_q <= ev_cnt_d;
      end
      if (cmd_i.take) begin
        hold_valid_q <= 1'b1;
      end else if (cmd_i.push) begin
        hold_valid_q <= 1'b0;
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign st_o.hold_valid = hold_valid_q;
  assign st_o.out_free   = !out_valid_q || out_ready_i;
  assign st_o.ev_cnt     = ev_cnt_q;

  assign out_valid_o  = out_valid_q;
  assign key_index_o  = out_key_q;
  assign event_kind_o = out_kind_q;
  assign held_ticks_o = out_held_q;
  assign last_o       = out_last_q;

endmodule

// ===== src/button_click_classifier.sv =====
// Button click classifier.
//
// Each beat on the input channel carries a snapshot of key levels and the
// current tick count. Every key runs its own click state machine, and the
// resulting press, release, long click, double click and short click events
// leave on the output channel one beat each, in ascending key order. The last
// event of an input beat carries last high; a beat that causes no event
// produces no output beat at all.
//
// The block handles one input beat at a time. A controller walks the keys one
// after another; each key passes through state read and elapsed-time
// subtraction, threshold compare and state update, one emit step per event it
// emits and an advance to the next key. Events pass through a hold slot into
// an output register, so the last flag is known before a beat is shown. When
// the receiver stalls, the walk pauses at the next event and resumes as soon
// as the output register drains. Reset puts every key into the released
// state and loads the debounce and short click limit registers with 30 and
// 300 ticks.
module button_click_classifier import bcc_pkg::*; #(
  parameter int unsigned NUM_KEYS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [TICK_W-1:0] cfg_data_i,
  bcc_in_if.sink            in_i,
  bcc_out_if.source         out_o
);

  // Key counter width; a single key still needs one bit.
  localparam int unsigned KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  bcc_cmd_t      cmd;
  bcc_status_t   status;
  logic [KW-1:0] key;

  // The controller sequences the key walk and the event hand-off.
  bcc_ctrl #(
    .NUM_KEYS (NUM_KEYS),
    .KW       (KW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .st_i       (status),
    .cmd_o      (cmd),
    .key_o      (key)
  );

  // The datapath holds key state, registers, timing compares and the
  // event hold and output stages.
  bcc_datapath #(
    .NUM_KEYS (NUM_KEYS),
    .KW       (KW)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .key_levels_i (in_i.key_levels),
    .now_ticks_i  (in_i.now_ticks),
    .cmd_i        (cmd),
    .key_i        (key),
    .st_o         (status),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .key_index_o  (out_o.key_index),
    .event_kind_o (out_o.event_kind),
    .held_ticks_o (out_o.held_ticks),
    .last_o       (out_o.last)
  );

endmodule

// ===== tb/button_click_classifier_tb.sv =====
`timescale 1ns / 1ps

module button_click_classifier_tb;
  import bcc_pkg::*;

  localparam int unsigned NUM_KEYS        = 16;
  // This settle time lets the block finish a beat that is still being walked
  // but will produce no event.
  localparam int unsigned SETTLE_CYCLES   = 150;
  localparam int unsigned LONG_STALL      = 600;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned N_PHASES        = 6;
  localparam int unsigned ITEMS_PER_PHASE = 42;
  localparam int unsigned N_DIRECTED      = 24;

  // One event beat as the classifier emits it.
  typedef struct packed {
    logic [KEY_IDX_W-1:0] key;
    ev_kind_e             kind;
    logic [TICK_W-1:0]    held;
    logic                 last;
  } click_ev_t;

  // A row of the directed table. Rows with typed set carry up to two events
  // written out by hand; the others are checked against the key tracker.
  typedef struct packed {
    logic [LEVEL_BITS-1:0] levels;
    logic [TICK_W-1:0]     ticks;
    logic                  typed;
    logic [1:0]            n_typed;
    click_ev_t             ev0;
    click_ev_t             ev1;
  } stim_row_t;

  typedef enum logic [1:0] {
    KEY_UP,
    KEY_FIRST_DOWN,
    KEY_WAIT_SECOND,
    KEY_SECOND_DOWN
  } key_phase_e;

  localparam click_ev_t NO_EVENT = '0;

  // The directed walk runs with the reset thresholds (debounce 30, limit 300).
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // Quiet snapshot right after reset.
    '{16'h0000, 32'd0,    1'b1, 2'd0, NO_EVENT, NO_EVENT},
    // Key 0: press, a bounce inside the debounce time, then a long hold.
    '{16'h0001, 32'd100,  1'b1, 2'd1, '{4'd0, EV_PRESS, 32'd0, 1'b1}, NO_EVENT},
    '{16'h0000, 32'd120,  1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{16'h0000, 32'd1100, 1'b1, 2'd2, '{4'd0, EV_RELEASE, 32'd0, 1'b0},
                                      '{4'd0, EV_LONG, 32'd1000, 1'b1}},
    // Key 1: short click whose double-click window runs out exactly at the limit.
    '{16'h0002, 32'd2000, 1'b1, 2'd1, '{4'd1, EV_PRESS, 32'd0, 1'b1}, NO_EVENT},
    '{16'h0000, 32'd2100, 1'b1, 2'd1, '{4'd1, EV_RELEASE, 32'd0, 1'b1}, NO_EVENT},
    '{16'h0000, 32'd2400, 1'b1, 2'd1, '{4'd1, EV_SHORT, 32'd0, 1'b1}, NO_EVENT},
    // Key 2: double click; the second press reports it and the second release is silent.
    '{16'h0004, 32'd3000, 1'b1, 2'd1, '{4'd2, EV_PRESS, 32'd0, 1'b1}, NO_EVENT},
    '{16'h0000, 32'd3050, 1'b1, 2'd1, '{4'd2, EV_RELEASE, 32'd0, 1'b1}, NO_EVENT},
    '{16'h0004, 32'd3100, 1'b1, 2'd1, '{4'd2, EV_DOUBLE, 32'd0, 1'b1}, NO_EVENT},
    '{16'h0004, 32'd3120, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{16'h0000, 32'd3200, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    // Key 3: release exactly at the debounce time is ignored, one tick later
    // it counts; the window is still open one tick below the limit.
    '{16'h0008, 32'd5000, 1'b1, 2'd1, '{4'd3, EV_PRESS, 32'd0, 1'b1}, NO_EVENT},
    '{16'h0000, 32'd5030, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{16'h0000, 32'd5031, 1'b1, 2'd1, '{4'd3, EV_RELEASE, 32'd0, 1'b1}, NO_EVENT},
    '{16'h0000, 32'd5330, 1'b1, 2'd0, NO_EVENT, NO_EVENT},
    '{16'h0000, 32'd5331, 1'b1, 2'd1, '{4'd3, EV_SHORT, 32'd0, 1'b1}, NO_EVENT},
    // All keys at once. Going back one tick in time makes the elapsed time
    // wrap to its maximum, so every key gives release plus long click: the
    // full 32 events of one beat.
    '{16'hFFFF, 32'd6000,       1'b0, 2'd0, NO_EVENT, NO_EVENT},
    '{16'h0000, 32'd5999,       1'b0, 2'd0, NO_EVENT, NO_EVENT},
    // Press at the top of the tick range, release after the counter wraps.
    '{16'hFFFF, 32'hFFFF_FFFF,  1'b0, 2'd0, NO_EVENT, NO_EVENT},
    '{16'h0000, 32'h0000_0063,  1'b0, 2'd0, NO_EVENT, NO_EVENT},
    // Odd keys double click, even keys time out into short clicks.
    '{16'hAAAA, 32'h0000_00A0,  1'b0, 2'd0, NO_EVENT, NO_EVENT},
    '{16'h0000, 32'h0000_0200,  1'b0, 2'd0, NO_EVENT, NO_EVENT},
    '{16'h5555, 32'h0000_0300,  1'b0, 2'd0, NO_EVENT, NO_EVENT}
  };

  // Threshold settings for the random part, extremes and inverted ones among
  // them (debounce at or above the limit makes short releases impossible).
  localparam logic [TICK_W-1:0] PHASE_DEBOUNCE [N_PHASES] = '{
    32'd30, 32'd0, 32'hFFFF_FFFF, 32'd4, 32'd0, 32'd100
  };
  localparam logic [TICK_W-1:0] PHASE_LIMIT [N_PHASES] = '{
    32'd300, 32'hFFFF_FFFF, 32'd0, 32'd20, 32'd1, 32'd100
  };

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [0:0]        cfg_idx_i;
  logic [TICK_W-1:0] cfg_data_i;

  bcc_in_if  in_if ();
  bcc_out_if out_if ();

  button_click_classifier #(
    .NUM_KEYS (NUM_KEYS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Tracker state: our own copy of each key's phase and last event time, and
  // of the two thresholds as last written.
  key_phase_e        key_phase_q [NUM_KEYS];
  logic [TICK_W-1:0] key_stamp_q [NUM_KEYS];
  logic [TICK_W-1:0] debounce_q;
  logic [TICK_W-1:0] click_limit_q;

  // Events still owed by the block, oldest first.
  click_ev_t pending_events [$];

  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned settings_run = 0;
  int unsigned kind_seen [5] = '{default: 0};
  int unsigned cycle_cnt = 0;

  // Idling control shared by both sides, and the one-time long receiver stall.
  logic idle_mode = 1'b1;
  logic long_stall_go = 1'b0;

  // Advances every key by one snapshot. When record is set, the events the
  // snapshot causes are queued as expectations, with last on the final one.
  function automatic void classify_snapshot(input logic [LEVEL_BITS-1:0] levels,
                                            input logic [TICK_W-1:0] ticks,
                                            input logic record);
    click_ev_t         evs [$];
    logic              pressed;
    logic [TICK_W-1:0] elapsed;
    for (int k = 0; k < NUM_KEYS; k++) begin
      pressed = (k < LEVEL_BITS) ? levels[k] : 1'b0;
      elapsed = ticks - key_stamp_q[k];
      case (key_phase_q[k])
        KEY_UP: begin
          if (pressed) begin
            key_stamp_q[k] = ticks;
            key_phase_q[k] = KEY_FIRST_DOWN;
            evs.push_back('{4'(k), EV_PRESS, '0, 1'b0});
          end
        end
        KEY_FIRST_DOWN: begin
          if (elapsed > debounce_q && !pressed) begin
            evs.push_back('{4'(k), EV_RELEASE, '0, 1'b0});
            if (elapsed < click_limit_q) begin
              key_stamp_q[k] = ticks;
              key_phase_q[k] = KEY_WAIT_SECOND;
            end else begin
              key_phase_q[k] = KEY_UP;
              evs.push_back('{4'(k), EV_LONG, elapsed, 1'b0});
            end
          end
        end
        KEY_WAIT_SECOND: begin
          // A second press inside the window is a double click; a window that
          // has run out turns the first click into a short click. Both tests
          // use the same elapsed time.
          if (elapsed > debounce_q && pressed && elapsed < click_limit_q) begin
            key_stamp_q[k] = ticks;
            key_phase_q[k] = KEY_SECOND_DOWN;
            evs.push_back('{4'(k), EV_DOUBLE, '0, 1'b0});
          end
          if (elapsed >= click_limit_q) begin
            key_phase_q[k] = KEY_UP;
            evs.push_back('{4'(k), EV_SHORT, '0, 1'b0});
          end
        end
        default: begin
          if (elapsed > debounce_q && !pressed) begin
            key_phase_q[k] = KEY_UP;
          end
        end
      endcase
    end
    if (evs.size() != 0) begin
      evs[evs.size() - 1].last = 1'b1;
    end
    if (record) begin
      foreach (evs[i]) pending_events.push_back(evs[i]);
    end
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // Offers one input beat, while idling is on at times with a random idle burst
  // ahead of it, and returns at the clock edge where the block takes it.
  task automatic send_beat(input logic [LEVEL_BITS-1:0] levels,
                           input logic [TICK_W-1:0] ticks);
    int unsigned gap;
    if (idle_mode && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.key_levels <= levels;
    in_if.now_ticks  <= ticks;
    do @(posedge clk_i); while (!in_if.ready);
    beats_sent++;
  endtask

  // Stops offering beats until every owed event has arrived, then lets the
  // block finish any beat that is still being walked without events.
  task automatic wait_for_quiet();
    in_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes both thresholds back to back; only called while the block is idle.
  task automatic set_thresholds(input logic [TICK_W-1:0] debounce,
                                input logic [TICK_W-1:0] limit);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_DEBOUNCE;
    cfg_data_i <= debounce;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_LIMIT;
    cfg_data_i <= limit;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    debounce_q    = debounce;
    click_limit_q = limit;
    settings_run++;
  endtask

  // Stimulus: reset, the directed table, then random phases with one setting
  // of the thresholds each, and finally the drain and the verdict.
  initial begin
    logic [LEVEL_BITS-1:0] levels_now;
    logic [TICK_W-1:0]     tick_now;
    logic [TICK_W-1:0]     step;
    logic                  quiet_tail;

    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_DEBOUNCE;
    cfg_data_i       = '0;
    in_if.valid      = 1'b0;
    in_if.key_levels = '0;
    in_if.now_ticks  = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_phase_q[k] = KEY_UP;
      key_stamp_q[k] = '0;
    end
    debounce_q    = DEBOUNCE_RST;
    click_limit_q = LIMIT_RST;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: typed rows queue their hand-written events, and the
    // tracker is still advanced so that it follows the block.
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_beat(DIRECTED[i].levels, DIRECTED[i].ticks);
      classify_snapshot(DIRECTED[i].levels, DIRECTED[i].ticks, !DIRECTED[i].typed);
      if (DIRECTED[i].typed && DIRECTED[i].n_typed > 0) begin
        pending_events.push_back(DIRECTED[i].ev0);
      end
      if (DIRECTED[i].typed && DIRECTED[i].n_typed > 1) begin
        pending_events.push_back(DIRECTED[i].ev1);
      end
    end

    levels_now = DIRECTED[N_DIRECTED - 1].levels;
    tick_now   = DIRECTED[N_DIRECTED - 1].ticks;

    for (int p = 0; p < N_PHASES; p++) begin
      wait_for_quiet();
      set_thresholds(PHASE_DEBOUNCE[p], PHASE_LIMIT[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // The last stretch of the run goes without any idling, otherwise
        // idling is switched on and off in stretches of 14 beats.
        quiet_tail = (p == N_PHASES - 1) && (i >= ITEMS_PER_PHASE - 30);
        if (quiet_tail) begin
          idle_mode <= 1'b0;
        end else if (i % 14 == 0) begin
          idle_mode <= ($urandom_range(0, 3) != 0);
        end

        // Early in the first phase the receiver holds off for a long stretch
        // while beats keep coming, so the block backs up into its input.
        if (p == 0 && i == 8) begin
          long_stall_go <= 1'b1;
        end
        // Once mid-phase the sender waits until every event has come back.
        if (p == 3 && i == ITEMS_PER_PHASE / 2) begin
          wait_for_quiet();
        end

        if ($urandom_range(0, 19) == 0) begin
          // Noise: an unrelated snapshot at an arbitrary time.
          levels_now = LEVEL_BITS'($urandom);
          tick_now   = $urandom;
        end else begin
          // Steps near the debounce time and the limit drive the keys through
          // their full click sequences; a few keys change per beat.
          case ($urandom_range(0, 4))
            0:       step = $urandom_range(0, 3);
            1:       step = debounce_q + $urandom_range(0, 2);
            2:       step = click_limit_q - $urandom_range(0, 2);
            3:       step = click_limit_q + $urandom_range(0, 3);
            default: step = $urandom_range(0, click_limit_q);
          endcase
          tick_now   = tick_now + step;
          levels_now = levels_now ^ LEVEL_BITS'($urandom & $urandom & $urandom);
        end
        send_beat(levels_now, tick_now);
        classify_snapshot(levels_now, tick_now, 1'b1);
      end
    end

    wait_for_quiet();
    $display("Sent %0d key snapshots (%0d directed) under %0d threshold settings.",
             beats_sent, N_DIRECTED, settings_run);
    $display("Events checked: %0d press, %0d release, %0d long, %0d double, %0d short.",
             kind_seen[EV_PRESS], kind_seen[EV_RELEASE], kind_seen[EV_LONG],
             kind_seen[EV_DOUBLE], kind_seen[EV_SHORT]);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Receiver: ready with random stall bursts while idling is on, plus one
  // long hold-off counted here.
  initial begin
    int unsigned stall_left;
    logic        long_stall_done;
    stall_left      = 0;
    long_stall_done = 1'b0;
    out_if.ready    = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
      end else if (long_stall_go && !long_stall_done) begin
        long_stall_done = 1'b1;
        stall_left      = LONG_STALL - 1;
        out_if.ready   <= 1'b0;
      end else if (idle_mode && $urandom_range(0, 5) == 0) begin
        stall_left    = $urandom_range(0, 12);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Each event beat is compared with the oldest owed event.
  always @(posedge clk_i) begin
    click_ev_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (out_if.event_kind < 5) begin
        kind_seen[out_if.event_kind]++;
      end
      if (pending_events.size() == 0) begin
        $error("unexpected event: key %0d kind %0d held %0d last %0d",
               out_if.key_index, out_if.event_kind, out_if.held_ticks, out_if.last);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        check_field("key_index",  32'(want.key),  32'(out_if.key_index));
        check_field("event_kind", 32'(want.kind), 32'(out_if.event_kind));
        check_field("held_ticks", want.held,      out_if.held_ticks);
        check_field("last",       32'(want.last), 32'(out_if.last));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d events still owed.",
               cycle_cnt, pending_events.size());
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
